>>> rtl/hbfm_pkg.sv
// Shared types, command codes and the 32-bit population count for the Hamming matcher.
package hbfm_pkg;

	localparam int CMD_W      = 2;
	localparam int WORD_W     = 64;
	localparam int DIST_W     = 9;
	localparam int QIDX_W     = 16;
	localparam int RIDX_W     = 10;
	localparam int POP_W      = 6;
	localparam int MAX_WORDS  = 8;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	localparam logic [DIST_W-1:0] DIST_NONE = 9'd256;
	localparam logic [DIST_W-1:0] THR_RESET = 9'd50;

	typedef logic [POP_W-1:0] pop_t;

	// SWAR population count of one 32-bit word, result 0..32
	function automatic pop_t pop32(input logic [31:0] v);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = v - ((v >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		return POP_W'({2'b00, c[7:0]} + {2'b00, c[15:8]} + {2'b00, c[23:16]}
			+ {2'b00, c[31:24]});
	endfunction

endpackage

>>> rtl/hamming_brute_force_matcher_core.sv
// Brute-force Hamming matcher: reference store, scan pipeline and result register.
//
// Load reference descriptors (cmd load) into an on-chip store of MAX_REFS entries, then
// send query descriptors (cmd query); each query returns one transaction with the index of
// the nearest stored reference (first one on ties), its Hamming distance over the lowest
// DESC_WORDS32 32-bit words (at most eight), the running query index and a found flag that
// is set when references exist and the distance is strictly below match_threshold. A clear
// command empties the store and restarts the query index; loads past capacity are dropped.
// A query scan reads one full reference from the single store port per cycle, so the
// number of loaded references sets its length. With an empty store the result has
// distance 256, ref_index 0 and found 0. The input is stalled while a query is being
// scanned and until its result enters the output register; a finished result waits in
// the output register while clear and load transactions keep flowing. Write
// match_threshold only while the block is idle.
module hamming_brute_force_matcher_core #(
	parameter int MAX_REFS     = 1024,
	parameter int DESC_WORDS32 = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_wr_en,
	input  logic [hbfm_pkg::DIST_W-1:0]       cfg_wr_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [hbfm_pkg::CMD_W-1:0]        cmd,
	input  logic [hbfm_pkg::WORD_W-1:0]       desc_word0,
	input  logic [hbfm_pkg::WORD_W-1:0]       desc_word1,
	input  logic [hbfm_pkg::WORD_W-1:0]       desc_word2,
	input  logic [hbfm_pkg::WORD_W-1:0]       desc_word3,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              found,
	output logic [hbfm_pkg::QIDX_W-1:0]       query_index,
	output logic [hbfm_pkg::RIDX_W-1:0]       ref_index,
	output logic [hbfm_pkg::DIST_W-1:0]       distance
);
	import hbfm_pkg::*;

	// only the lowest words up to the eighth take part; store just those bits
	localparam int NUM_WORDS = (DESC_WORDS32 > MAX_WORDS) ? MAX_WORDS : DESC_WORDS32;
	localparam int ST_W      = 32 * NUM_WORDS;
	localparam int AW        = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int CW        = $clog2(MAX_REFS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          ref_count_q;
	logic [QIDX_W-1:0]      query_cnt_q;
	logic [DIST_W-1:0]      thr_q;
	logic [ST_W-1:0]        query_q;
	logic [QIDX_W-1:0]      qidx_q;
	logic [CW-1:0]          issue_q;
	logic [DIST_W-1:0]      best_dist_q;
	logic [AW-1:0]          best_idx_q;

	// reference store, one full descriptor per entry
	logic [ST_W-1:0]        ref_mem [MAX_REFS];

	logic                   in_fire;
	logic [4*WORD_W-1:0]    desc_all;
	logic                   load_en;
	logic                   issue_en;
	logic                   scan_done;
	logic                   res_load;

	// scan pipeline: read, per-word count, sum and compare
	logic                   v_s1;
	logic [AW-1:0]          idx_s1;
	logic [ST_W-1:0]        rdata_s1;
	logic                   v_s2;
	logic [AW-1:0]          idx_s2;
	pop_t                   pop_s2 [NUM_WORDS];
	logic [DIST_W-1:0]      dist_sum;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign desc_all  = {desc_word3, desc_word2, desc_word1, desc_word0};
	assign load_en   = in_fire && (cmd == CMD_LOAD) && (ref_count_q < CW'(MAX_REFS));
	assign issue_en  = (state_q == ST_SCAN) && (issue_q < ref_count_q);
	assign scan_done = (state_q == ST_SCAN) && (issue_q == ref_count_q) && !v_s1 && !v_s2;
	// finished result moves into the output register when it is free
	assign res_load  = (state_q == ST_FIN) && (!out_valid || !out_stall);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// store write on load, registered read during the scan
	always_ff @(posedge clk) begin
		if (load_en) begin
			ref_mem[ref_count_q[AW-1:0]] <= desc_all[ST_W-1:0];
		end
		rdata_s1 <= ref_mem[issue_q[AW-1:0]];
	end

	// counters and the held query
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_count_q <= '0;
			query_cnt_q <= '0;
		end else if (in_fire) begin
			case (cmd)
				CMD_CLEAR: begin
					ref_count_q <= '0;
					query_cnt_q <= '0;
				end
				CMD_LOAD: begin
					if (load_en) begin
						ref_count_q <= ref_count_q + CW'(1);
					end
				end
				CMD_QUERY: begin
					query_cnt_q <= query_cnt_q + QIDX_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && (cmd == CMD_QUERY)) begin
			query_q <= desc_all[ST_W-1:0];
			qidx_q  <= query_cnt_q;
		end
	end

	// read address sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
		end else if (in_fire && (cmd == CMD_QUERY)) begin
			issue_q <= '0;
		end else if (issue_en) begin
			issue_q <= issue_q + CW'(1);
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1;
		end
	end

	// stage 2: XOR with the query and count each 32-bit word
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		idx_s2 <= idx_s1;
		for (int i = 0; i < NUM_WORDS; i++) begin
			pop_s2[i] <= pop32(rdata_s1[32*i +: 32] ^ query_q[32*i +: 32]);
		end
	end

	always_comb begin
		dist_sum = '0;
		for (int i = 0; i < NUM_WORDS; i++) begin
			dist_sum = dist_sum + DIST_W'(pop_s2[i]);
		end
	end

	// stage 3: keep the first strict minimum
	always_ff @(posedge clk) begin
		if (in_fire && (cmd == CMD_QUERY)) begin
			best_dist_q <= DIST_NONE;
			best_idx_q  <= '0;
		end else if (v_s2 && (dist_sum < best_dist_q)) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s2;
		end
	end

	// control state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			// load a finished result, or drop one once the receiver takes it
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (cmd == CMD_QUERY)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found       <= (ref_count_q != '0) && (best_dist_q < thr_q);
			query_index <= qidx_q;
			ref_index   <= RIDX_W'(best_idx_q);
			distance    <= best_dist_q;
		end
	end

endmodule

>>> verif/hamming_brute_force_matcher_core_tb.sv
// Self-checking testbench for the brute-force Hamming descriptor matcher core.
module hamming_brute_force_matcher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hbfm_pkg::*;

	localparam int MAX_REFS       = 1024;
	localparam int DESC_WORDS32   = 8;
	localparam int DESC_BITS      = 256;
	localparam int IDLE_LIMIT     = 10000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int SMALL_STORE    = 32;
	localparam int MAX_REPORTS    = 10;

	// code 3 has no name in the package; the block must swallow it silently
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef logic [DESC_BITS-1:0] desc_t;

	typedef struct {
		logic              found;
		logic [QIDX_W-1:0] qidx;
		logic [RIDX_W-1:0] ridx;
		logic [DIST_W-1:0] hdist;
	} match_t;

	// Nearest-neighbor predictor plus the queue of matches still owed by the block.
	class match_scoreboard;
		desc_t             store_desc[MAX_REFS];
		int unsigned       n_loaded;
		logic [QIDX_W-1:0] next_qidx;
		logic [DIST_W-1:0] threshold;
		match_t            owed_q[$];
		int                errors;

		function new();
			n_loaded  = 0;
			next_qidx = '0;
			threshold = THR_RESET;
			errors    = 0;
		endfunction

		function int unsigned hamming(desc_t a, desc_t b);
			desc_t x;
			x = a ^ b;
			for (int i = DESC_WORDS32 * 32; i < DESC_BITS; i++)
				x[i] = 1'b0;
			return $countones(x);
		endfunction

		// Apply one accepted transaction to the predictor state.
		function void note_item(logic [CMD_W-1:0] op, desc_t d);
			match_t      m;
			int unsigned best;
			int unsigned best_idx;
			int unsigned hd;
			case (op)
				CMD_CLEAR: begin
					n_loaded  = 0;
					next_qidx = '0;
				end
				CMD_LOAD: begin
					if (n_loaded < MAX_REFS) begin
						store_desc[n_loaded] = d;
						n_loaded++;
					end
				end
				CMD_QUERY: begin
					best     = 256;
					best_idx = 0;
					for (int unsigned r = 0; r < n_loaded; r++) begin
						hd = hamming(d, store_desc[r]);
						if (r == 0 || hd < best) begin
							best     = hd;
							best_idx = r;
						end
					end
					m.found = (n_loaded > 0) && (best < threshold);
					m.qidx  = next_qidx;
					m.ridx  = RIDX_W'(best_idx);
					m.hdist = DIST_W'(best);
					owed_q = {owed_q, m};
					next_qidx++;
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic f, logic [QIDX_W-1:0] q, logic [RIDX_W-1:0] r,
			logic [DIST_W-1:0] hd);
			match_t e;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: found=%0d qidx=%0d ref=%0d dist=%0d",
						f, q, r, hd);
				return;
			end
			e = owed_q.pop_front();
			if (f !== e.found || q !== e.qidx || r !== e.ridx || hd !== e.hdist) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"mismatch: exp found=%0d qidx=%0d ref=%0d dist=%0d, ",
						"got found=%0d qidx=%0d ref=%0d dist=%0d"},
						e.found, e.qidx, e.ridx, e.hdist, f, q, r, hd);
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function void close_out();
			if (owed_q.size() != 0) begin
				$display("%0d results never arrived", owed_q.size());
				errors += owed_q.size();
			end
		endfunction
	endclass

	// DUT-facing signals, all inputs known from time zero
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [DIST_W-1:0] cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  cmd         = CMD_CLEAR;
	logic [WORD_W-1:0] desc_word0  = '0;
	logic [WORD_W-1:0] desc_word1  = '0;
	logic [WORD_W-1:0] desc_word2  = '0;
	logic [WORD_W-1:0] desc_word3  = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              found;
	logic [QIDX_W-1:0] query_index;
	logic [RIDX_W-1:0] ref_index;
	logic [DIST_W-1:0] distance;

	// idling knobs: sender is touched only by the main process, receiver knobs are
	// written at a rising edge and read at a falling edge, so there is no race
	int send_idle_pct = 0;
	int rx_stall_pct  = 0;
	bit rx_hold_go    = 1'b0;
	int rx_hold_left  = 0;
	int idle_cycles   = 0;

	match_scoreboard sb;

	hamming_brute_force_matcher_core #(
		.MAX_REFS     (MAX_REFS),
		.DESC_WORDS32 (DESC_WORDS32)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.desc_word0  (desc_word0),
		.desc_word1  (desc_word1),
		.desc_word2  (desc_word2),
		.desc_word3  (desc_word3),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.query_index (query_index),
		.ref_index   (ref_index),
		.distance    (distance)
	);

	always #6 clk = ~clk;

	// Receiver: drive stall at the falling edge. A requested hold-off keeps stall
	// high for a fixed stretch counted here, otherwise stall is random per cycle.
	always @(negedge clk) begin
		if (rx_hold_go) begin
			rx_hold_go   = 1'b0;
			rx_hold_left = RX_HOLD_CYCLES;
		end
		if (rx_hold_left > 0) begin
			out_stall <= 1'b1;
			rx_hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Sample every accepted result at the rising edge and check it in order.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_result(found, query_index, ref_index, distance);
	end

	// Watchdog: count cycles without any transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic desc_t rand_desc();
		desc_t d;
		for (int i = 0; i < DESC_BITS / 32; i++)
			d[i*32 +: 32] = $urandom;
		return d;
	endfunction

	// flip n random bits (repeats allowed, so the distance is at most n)
	function automatic desc_t flip_random(desc_t d, int n);
		desc_t x;
		x = d;
		for (int i = 0; i < n; i++)
			x[$urandom_range(DESC_BITS - 1)] ^= 1'b1;
		return x;
	endfunction

	// flip exactly n distinct bits spread over the whole descriptor
	function automatic desc_t flip_exact(desc_t d, int n);
		desc_t x;
		x = d;
		for (int i = 0; i < n; i++)
			x[i*5] ^= 1'b1;
		return x;
	endfunction

	// Offer one transaction at the falling edge, hold it until accepted, then
	// drop valid for a random number of cycles when the sender is idling.
	task automatic send_item(input logic [CMD_W-1:0] op, input desc_t d);
		cmd        <= op;
		desc_word0 <= d[63:0];
		desc_word1 <= d[127:64];
		desc_word2 <= d[191:128];
		desc_word3 <= d[255:192];
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.note_item(op, d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	// Stop offering and wait until every owed result has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Threshold writes happen only with the block idle; clear and load produce
	// no result, so let a few cycles pass after the last result as well.
	task automatic write_threshold(input logic [DIST_W-1:0] v);
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		sb.threshold = v;
	endtask

	// call only after wait_drain, so no transaction is on offer at the rising edge
	task automatic set_idling(input int s, input int r);
		@(posedge clk);
		send_idle_pct = s;
		rx_stall_pct  = r;
		@(negedge clk);
	endtask

	// Stall the result side for a long stretch while the sender keeps pushing.
	task automatic hold_receiver();
		wait_drain();
		@(posedge clk);
		rx_hold_go = 1'b1;
		@(negedge clk);
	endtask

	// Mostly well-formed traffic on a small store: loads that repeat or sit near
	// earlier references to create ties, queries near stored references so the
	// distance lands around the threshold, and some clears, noise and code 3.
	task automatic run_random(input int count);
		int               pick;
		int               sel;
		logic [CMD_W-1:0] op;
		desc_t            d;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			sel  = $urandom_range(9);
			d    = rand_desc();
			if (pick < 6) begin
				op = CMD_CLEAR;
			end else if (pick < 9) begin
				op = CMD_UNUSED;
			end else if (pick < 40 && sb.n_loaded < SMALL_STORE) begin
				op = CMD_LOAD;
				if (sb.n_loaded > 0 && sel < 2)
					d = sb.store_desc[$urandom_range(sb.n_loaded - 1)];
				else if (sb.n_loaded > 0 && sel < 4)
					d = flip_random(sb.store_desc[$urandom_range(sb.n_loaded - 1)],
						$urandom_range(1, 8));
			end else begin
				op = CMD_QUERY;
				if (sb.n_loaded > 0 && sel < 7)
					d = flip_random(sb.store_desc[$urandom_range(sb.n_loaded - 1)],
						$urandom_range(0, 64));
			end
			send_item(op, d);
		end
	endtask

	initial begin : main
		desc_t all_zero;
		desc_t all_one;
		desc_t alt_bits;
		desc_t seed_ref;
		all_zero = '0;
		all_one  = '1;
		alt_bits = {(DESC_BITS / 4){4'h5}};
		sb       = new();

		// hold reset, then release it at a falling edge
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty store, unused code, extreme patterns, ties, single-bit
		// distances at both ends of the word, clear and the threshold boundary
		send_item(CMD_QUERY, rand_desc());
		send_item(CMD_UNUSED, rand_desc());
		send_item(CMD_LOAD, all_zero);
		send_item(CMD_LOAD, all_one);
		send_item(CMD_LOAD, all_zero);
		send_item(CMD_LOAD, alt_bits);
		send_item(CMD_QUERY, all_zero);
		send_item(CMD_QUERY, all_one);
		send_item(CMD_QUERY, ~alt_bits);
		send_item(CMD_QUERY, desc_t'(1) << (DESC_BITS - 1));
		send_item(CMD_QUERY, desc_t'(1));
		send_item(CMD_CLEAR, rand_desc());
		send_item(CMD_QUERY, rand_desc());
		seed_ref = rand_desc();
		send_item(CMD_LOAD, seed_ref);
		send_item(CMD_QUERY, flip_exact(seed_ref, THR_RESET - 1));
		send_item(CMD_QUERY, flip_exact(seed_ref, THR_RESET));
		send_item(CMD_UNUSED, all_one);

		// no idling, threshold above any distance; includes a long receiver hold
		write_threshold(9'd257);
		set_idling(0, 0);
		run_random(100);
		hold_receiver();
		run_random(45);

		// sender idles most of the time
		write_threshold(DIST_W'($urandom_range(20, 80)));
		set_idling(66, 0);
		run_random(140);

		// receiver stalls most of the time, threshold zero never matches
		write_threshold(9'd0);
		set_idling(0, 66);
		run_random(140);

		// light idling on both sides
		write_threshold(DIST_W'($urandom_range(1, 256)));
		set_idling(12, 12);
		run_random(140);

		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
